// ===== rtl/gws_pkg.sv =====
// Shared types and constants for the grid word search block.
`default_nettype none

package gws_pkg;

  // Request operation codes
  localparam logic [1:0] OP_GRID_WR = 2'd0;
  localparam logic [1:0] OP_PAT_WR  = 2'd1;
  localparam logic [1:0] OP_SEARCH  = 2'd2;

  // Sequencer program counter width
  localparam int PC_W   = 4;
  localparam int COND_W = 3;

  localparam int CFG_W = 5;

  typedef struct packed {
    logic [1:0] operation;
    logic [4:0] row;
    logic [4:0] column;
    logic [3:0] pattern_position;
    logic [7:0] character;
  } gws_in_t;

  typedef struct packed {
    logic       found;
    logic [2:0] direction;
    logic [4:0] start_row;
    logic [4:0] start_column;
    logic       last;
  } gws_out_t;

  // Control word: one per microcode step
  typedef struct packed {
    logic              take;
    logic              dispatch;
    logic              grid_wr;
    logic              pat_wr;
    logic              rd_start;
    logic              dir_clr;
    logic              line_init;
    logic              rd_step;
    logic              k_inc;
    logic              dir_inc;
    logic              act_hit;
    logic              act_end;
    logic [COND_W-1:0] cond;
    logic [PC_W-1:0]   tgt_t;
    logic [PC_W-1:0]   tgt_f;
  } gws_ctl_t;

  // Datapath status seen by the sequencer
  typedef struct packed {
    logic       in_valid;
    logic [1:0] op;
    logic       start_out;
    logic       ne;
    logic       k_done;
    logic       edge_hit;
    logic       dir_last;
    logic       hit_wait;
    logic       out_busy;
  } gws_stat_t;

endpackage

`default_nettype wire

// ===== rtl/gws_ram.sv =====
// Generic RAM: one write port, one read port with registered read data.
`default_nettype none

module gws_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                                  clk,
  input  wire logic                                  wr_en,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]                      wr_data,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic      [WIDTH-1:0]                      rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

// ===== rtl/gws_seq.sv =====
// Microcode sequencer: program ROM, step counter and branch logic.
`default_nettype none

module gws_seq (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire gws_pkg::gws_stat_t stat,
  output gws_pkg::gws_ctl_t     ctl
);

  import gws_pkg::*;

  // Program steps
  localparam logic [PC_W-1:0] P_IDLE  = 4'd0;
  localparam logic [PC_W-1:0] P_WG    = 4'd1;
  localparam logic [PC_W-1:0] P_WP    = 4'd2;
  localparam logic [PC_W-1:0] P_START = 4'd3;
  localparam logic [PC_W-1:0] P_CMP0  = 4'd4;
  localparam logic [PC_W-1:0] P_LINE  = 4'd5;
  localparam logic [PC_W-1:0] P_STEP  = 4'd6;
  localparam logic [PC_W-1:0] P_LCMP  = 4'd7;
  localparam logic [PC_W-1:0] P_HIT   = 4'd8;
  localparam logic [PC_W-1:0] P_NEXT  = 4'd9;
  localparam logic [PC_W-1:0] P_END   = 4'd10;

  // Branch conditions
  localparam logic [COND_W-1:0] C_ALWAYS    = 3'd0;
  localparam logic [COND_W-1:0] C_START_OUT = 3'd1;
  localparam logic [COND_W-1:0] C_NE        = 3'd2;
  localparam logic [COND_W-1:0] C_K_DONE    = 3'd3;
  localparam logic [COND_W-1:0] C_EDGE      = 3'd4;
  localparam logic [COND_W-1:0] C_DIR_LAST  = 3'd5;
  localparam logic [COND_W-1:0] C_HIT_WAIT  = 3'd6;
  localparam logic [COND_W-1:0] C_OUT_BUSY  = 3'd7;

  function automatic gws_ctl_t rom(input logic [PC_W-1:0] a);
    gws_ctl_t w;
    w = '0;
    w.cond  = C_ALWAYS;
    w.tgt_t = P_IDLE;
    w.tgt_f = P_IDLE;
    case (a)
      P_IDLE: begin
        w.take     = 1'b1;
        w.dispatch = 1'b1;
      end
      P_WG: begin
        w.grid_wr = 1'b1;
      end
      P_WP: begin
        w.pat_wr = 1'b1;
      end
      P_START: begin
        w.rd_start  = 1'b1;
        w.dir_clr   = 1'b1;
        w.line_init = 1'b1;
        w.cond      = C_START_OUT;
        w.tgt_t     = P_END;
        w.tgt_f     = P_CMP0;
      end
      P_CMP0: begin
        w.cond  = C_NE;
        w.tgt_t = P_END;
        w.tgt_f = P_LINE;
      end
      P_LINE: begin
        w.cond  = C_K_DONE;
        w.tgt_t = P_HIT;
        w.tgt_f = P_STEP;
      end
      P_STEP: begin
        w.rd_step = 1'b1;
        w.cond    = C_EDGE;
        w.tgt_t   = P_NEXT;
        w.tgt_f   = P_LCMP;
      end
      P_LCMP: begin
        w.k_inc = 1'b1;
        w.cond  = C_NE;
        w.tgt_t = P_NEXT;
        w.tgt_f = P_LINE;
      end
      P_HIT: begin
        w.act_hit = 1'b1;
        w.cond    = C_HIT_WAIT;
        w.tgt_t   = P_HIT;
        w.tgt_f   = P_NEXT;
      end
      P_NEXT: begin
        w.dir_inc   = 1'b1;
        w.line_init = 1'b1;
        w.cond      = C_DIR_LAST;
        w.tgt_t     = P_END;
        w.tgt_f     = P_LINE;
      end
      P_END: begin
        w.act_end = 1'b1;
        w.cond    = C_OUT_BUSY;
        w.tgt_t   = P_END;
        w.tgt_f   = P_IDLE;
      end
      default: begin
        w.cond = C_ALWAYS;
      end
    endcase
    return w;
  endfunction

  logic [PC_W-1:0] pc_r;
  logic [PC_W-1:0] pc_nxt;
  logic            cond_true;
  logic [PC_W-1:0] disp_pc;

  assign ctl = rom(pc_r);

  always_comb begin
    case (ctl.cond)
      C_ALWAYS:    cond_true = 1'b1;
      C_START_OUT: cond_true = stat.start_out;
      C_NE:        cond_true = stat.ne;
      C_K_DONE:    cond_true = stat.k_done;
      C_EDGE:      cond_true = stat.edge_hit;
      C_DIR_LAST:  cond_true = stat.dir_last;
      C_HIT_WAIT:  cond_true = stat.hit_wait;
      C_OUT_BUSY:  cond_true = stat.out_busy;
      default:     cond_true = 1'b1;
    endcase
  end

  always_comb begin
    case (stat.op)
      OP_GRID_WR: disp_pc = P_WG;
      OP_PAT_WR:  disp_pc = P_WP;
      OP_SEARCH:  disp_pc = P_START;
      default:    disp_pc = P_IDLE;
    endcase
  end

  always_comb begin
    if (ctl.dispatch) begin
      pc_nxt = stat.in_valid ? disp_pc : pc_r;
    end else begin
      pc_nxt = cond_true ? ctl.tgt_t : ctl.tgt_f;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= P_IDLE;
    end else begin
      pc_r <= pc_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/grid_word_search_eight_dir_top.sv =====
// Top level of the eight-direction grid word search: datapath, RAMs and sequencer.
`default_nettype none

// Channel  Direction  Handshake           Payload
// in_      request    in_valid/in_stall   gws_in_t: operation, row, column, position, char
// out_     result     out_valid/out_stall gws_out_t: found, direction, start cell, last
// cfg_     write      cfg_valid/cfg_ready pattern_length (5 bits)
//
// A search spends three sequencer steps per pattern cell in each of the eight lines, plus any
// wait on the result side; the steps are set by the single grid RAM read port feeding one compare
// per cell. Lines that leave the grid or mismatch end early. Reset clears the sequencer,
// result valid flags and pattern length (back to 1); grid and pattern contents are undefined
// until written. A stalled result holds the sequencer only when a further result must be
// delivered.

module grid_word_search_eight_dir_top #(
  parameter int GRID_ROWS   = 32,
  parameter int GRID_COLS   = 24,
  parameter int PATTERN_MAX = 16
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     in_valid,
  output logic                          in_stall,
  input  wire gws_pkg::gws_in_t         in_data,
  output logic                          out_valid,
  input  wire logic                     out_stall,
  output gws_pkg::gws_out_t             out_data,
  input  wire logic                     cfg_valid,
  output logic                          cfg_ready,
  input  wire logic [gws_pkg::CFG_W-1:0] cfg_data
);

  import gws_pkg::*;

  localparam int CRW   = $clog2(GRID_ROWS) + 1;   // room for one step past either edge
  localparam int CCW   = $clog2(GRID_COLS) + 1;
  localparam int GDEP  = GRID_ROWS * GRID_COLS;
  localparam int GAW   = GDEP > 1 ? $clog2(GDEP) : 1;
  localparam int PAW   = PATTERN_MAX > 1 ? $clog2(PATTERN_MAX) : 1;
  localparam int LW    = $clog2(PATTERN_MAX + 1);

  localparam logic [2:0] DIR_UP         = 3'd0;
  localparam logic [2:0] DIR_UP_RIGHT   = 3'd1;
  localparam logic [2:0] DIR_RIGHT      = 3'd2;
  localparam logic [2:0] DIR_DOWN_RIGHT = 3'd3;
  localparam logic [2:0] DIR_DOWN       = 3'd4;
  localparam logic [2:0] DIR_DOWN_LEFT  = 3'd5;
  localparam logic [2:0] DIR_LEFT       = 3'd6;
  localparam logic [2:0] DIR_UP_LEFT    = 3'd7;

  gws_ctl_t  ctl;
  gws_stat_t stat;

  // Request latched at accept
  gws_in_t req_r;

  // Walk state
  logic [2:0]     dir_r;
  logic [LW-1:0]  k_r;
  logic [CRW-1:0] cur_row_r;
  logic [CCW-1:0] cur_col_r;

  // Pending match: held back until we know whether it is the last one
  logic           pend_v_r;
  logic [2:0]     pend_dir_r;

  logic [CFG_W-1:0] cfg_len_r;
  logic [LW-1:0]    len_used;

  logic             out_valid_r;
  gws_out_t         out_r;
  logic             out_free;

  logic             req_in_grid;
  logic             pos_ok;
  logic [CRW-1:0]   start_row;
  logic [CCW-1:0]   start_col;
  logic             row_inc, row_dec, col_inc, col_dec;
  logic [CRW-1:0]   nxt_row;
  logic [CCW-1:0]   nxt_col;
  logic             nxt_out;

  logic [GAW-1:0]   grid_waddr;
  logic [GAW-1:0]   grid_raddr;
  logic [7:0]       grid_q;
  logic [PAW-1:0]   pat_raddr;
  logic [7:0]       pat_q;

  logic             hit_wait;
  logic             hit_fire;
  logic             end_fire;

  function automatic logic [GAW-1:0] cell_addr(input logic [CRW-1:0] r,
                                               input logic [CCW-1:0] c);
    return GAW'(32'(r) * GRID_COLS + 32'(c));
  endfunction

  // ---------------------------------------------------------------- control
  gws_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .stat  (stat),
    .ctl   (ctl)
  );

  assign in_stall  = !ctl.take;
  assign cfg_ready = 1'b1;

  // ---------------------------------------------------------------- config
  // Clamp the length: zero acts as one, above capacity acts as capacity.
  always_comb begin
    if (cfg_len_r == '0) begin
      len_used = LW'(1);
    end else if (32'(cfg_len_r) > PATTERN_MAX) begin
      len_used = LW'(PATTERN_MAX);
    end else begin
      len_used = LW'(cfg_len_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_len_r <= CFG_W'(1);
    end else if (cfg_valid && cfg_ready) begin
      cfg_len_r <= cfg_data;
    end
  end

  // ---------------------------------------------------------------- request
  always_ff @(posedge clk) begin
    if (ctl.take && in_valid) begin
      req_r <= in_data;
    end
  end

  assign req_in_grid = (32'(req_r.row) < GRID_ROWS) && (32'(req_r.column) < GRID_COLS);
  assign pos_ok      = 32'(req_r.pattern_position) < PATTERN_MAX;
  assign start_row   = CRW'(req_r.row);
  assign start_col   = CCW'(req_r.column);

  // ---------------------------------------------------------------- stepping
  assign row_dec = (dir_r == DIR_UP) || (dir_r == DIR_UP_RIGHT) || (dir_r == DIR_UP_LEFT);
  assign row_inc = (dir_r == DIR_DOWN_RIGHT) || (dir_r == DIR_DOWN) ||
                   (dir_r == DIR_DOWN_LEFT);
  assign col_inc = (dir_r == DIR_UP_RIGHT) || (dir_r == DIR_RIGHT) ||
                   (dir_r == DIR_DOWN_RIGHT);
  assign col_dec = (dir_r == DIR_DOWN_LEFT) || (dir_r == DIR_LEFT) ||
                   (dir_r == DIR_UP_LEFT);

  // Stepping below zero wraps to all ones, which is past the far edge as well.
  assign nxt_row = row_inc ? cur_row_r + 1'b1 : (row_dec ? cur_row_r - 1'b1 : cur_row_r);
  assign nxt_col = col_inc ? cur_col_r + 1'b1 : (col_dec ? cur_col_r - 1'b1 : cur_col_r);
  assign nxt_out = (32'(nxt_row) >= GRID_ROWS) || (32'(nxt_col) >= GRID_COLS);

  always_ff @(posedge clk) begin
    if (ctl.dir_clr) begin
      dir_r <= DIR_UP;
    end else if (ctl.dir_inc) begin
      dir_r <= dir_r + 1'b1;
    end

    if (ctl.line_init) begin
      cur_row_r <= start_row;
      cur_col_r <= start_col;
    end else if (ctl.rd_step) begin
      cur_row_r <= nxt_row;
      cur_col_r <= nxt_col;
    end

    if (ctl.line_init) begin
      k_r <= LW'(1);
    end else if (ctl.k_inc) begin
      k_r <= k_r + 1'b1;
    end
  end

  // ---------------------------------------------------------------- storage
  assign grid_waddr = cell_addr(start_row, start_col);
  assign grid_raddr = ctl.rd_start ? cell_addr(start_row, start_col)
                                   : cell_addr(nxt_row, nxt_col);
  assign pat_raddr  = ctl.rd_start ? '0 : PAW'(k_r);

  gws_ram #(
    .WIDTH (8),
    .DEPTH (GDEP)
  ) u_grid_ram (
    .clk     (clk),
    .wr_en   (ctl.grid_wr && req_in_grid),
    .wr_addr (grid_waddr),
    .wr_data (req_r.character),
    .rd_addr (grid_raddr),
    .rd_data (grid_q)
  );

  gws_ram #(
    .WIDTH (8),
    .DEPTH (PATTERN_MAX)
  ) u_pat_ram (
    .clk     (clk),
    .wr_en   (ctl.pat_wr && pos_ok),
    .wr_addr (PAW'(req_r.pattern_position)),
    .wr_data (req_r.character),
    .rd_addr (pat_raddr),
    .rd_data (pat_q)
  );

  // ---------------------------------------------------------------- results
  assign out_free = !out_valid_r || !out_stall;
  // A new hit only has to wait when an earlier one must go out first.
  assign hit_wait = pend_v_r && !out_free;
  assign hit_fire = ctl.act_hit && !hit_wait;
  assign end_fire = ctl.act_end && out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (ctl.rd_start) begin
        pend_v_r <= 1'b0;
      end else if (hit_fire) begin
        pend_v_r <= 1'b1;
      end

      if (hit_fire && pend_v_r) begin
        out_valid_r <= 1'b1;
      end else if (end_fire) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (hit_fire) begin
      pend_dir_r <= dir_r;
    end

    if (hit_fire && pend_v_r) begin
      // Earlier hit goes out; a later one exists so it is not last.
      out_r.found        <= 1'b1;
      out_r.direction    <= pend_dir_r;
      out_r.start_row    <= req_r.row;
      out_r.start_column <= req_r.column;
      out_r.last         <= 1'b0;
    end else if (end_fire) begin
      out_r.found        <= pend_v_r;
      out_r.direction    <= pend_v_r ? pend_dir_r : DIR_UP;
      out_r.start_row    <= req_r.row;
      out_r.start_column <= req_r.column;
      out_r.last         <= 1'b1;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // ---------------------------------------------------------------- status
  always_comb begin
    stat           = '0;
    stat.in_valid  = in_valid;
    stat.op        = in_data.operation;
    stat.start_out = !req_in_grid;
    stat.ne        = grid_q != pat_q;
    stat.k_done    = k_r >= len_used;
    stat.edge_hit  = nxt_out;
    stat.dir_last  = dir_r == DIR_UP_LEFT;
    stat.hit_wait  = hit_wait;
    stat.out_busy  = !out_free;
  end

endmodule

`default_nettype wire

// ===== sim/tb_top.sv =====
// Testbench for the eight-direction grid word search block: stimulus, prediction and checking.
`timescale 1ns / 100ps

module tb_top;
  import gws_pkg::*;

  localparam int GRID_ROWS   = 32;
  localparam int GRID_COLS   = 24;
  localparam int PATTERN_MAX = 16;

  // Operation code the block leaves unused; such a request must be dropped.
  localparam logic [1:0] OP_UNUSED = 2'd3;

  // Direction codes in reporting order.
  localparam logic [2:0] DIR_UP         = 3'd0;
  localparam logic [2:0] DIR_UP_RIGHT   = 3'd1;
  localparam logic [2:0] DIR_RIGHT      = 3'd2;
  localparam logic [2:0] DIR_DOWN_RIGHT = 3'd3;
  localparam logic [2:0] DIR_DOWN       = 3'd4;
  localparam logic [2:0] DIR_DOWN_LEFT  = 3'd5;
  localparam logic [2:0] DIR_LEFT       = 3'd6;
  localparam logic [2:0] DIR_UP_LEFT    = 3'd7;

  // Settle beyond the longest search.
  localparam int SETTLE_CYCLES  = 450;
  localparam int HOLDOFF_CYCLES = 600;
  localparam int CYCLE_LIMIT    = 500000;
  localparam int IDLE_PERCENT   = 36;

  logic                 clk       = 1'b0;
  logic                 rst_n     = 1'b0;
  logic                 in_valid  = 1'b0;
  logic                 in_stall;
  gws_in_t              in_data   = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  gws_out_t             out_data;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_W-1:0]     cfg_data  = '0;

  // Shadow copy of the block's state, kept in step with every accepted request.
  logic [7:0]           grid_model [0:GRID_ROWS-1][0:GRID_COLS-1];
  logic [7:0]           pattern_model [0:PATTERN_MAX-1];
  logic [CFG_W-1:0]     pattern_len_model = 5'd1;

  // Cells written so far; a search may only read these.
  bit                   grid_written [0:GRID_ROWS-1][0:GRID_COLS-1];

  // Start cell of the most recently planted word.
  int                   plant_row = 0;
  int                   plant_col = 0;

  // Match reports still owed by the block, oldest first.
  gws_out_t             match_reports [$];
  gws_out_t             want;
  int                   mismatch_count = 0;
  int                   cycle_count    = 0;

  // Idling controls: the sender idles only when in_idle_on, the receiver when out_idle_on.
  bit                   in_idle_on  = 1'b1;
  bit                   out_idle_on = 1'b1;
  int                   holdoff_requests = 0;
  int                   holdoff_served   = 0;
  int                   holdoff_left     = 0;

  grid_word_search_eight_dir_top #(
    .GRID_ROWS  (GRID_ROWS),
    .GRID_COLS  (GRID_COLS),
    .PATTERN_MAX(PATTERN_MAX)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data)
  );

  always #2 clk = ~clk;

  // Abort a hung run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // Result-side stall: a requested hold-off wins, otherwise stall at random while idling is on.
  always @(posedge clk) begin
    if (holdoff_left > 0) begin
      out_stall    <= 1'b1;
      holdoff_left <= holdoff_left - 1;
    end else if (holdoff_served != holdoff_requests) begin
      holdoff_served <= holdoff_requests;
      holdoff_left   <= HOLDOFF_CYCLES;
      out_stall      <= 1'b1;
    end else begin
      out_stall <= out_idle_on && ($urandom_range(99) < IDLE_PERCENT);
    end
  end

  function automatic int row_step(input int d);
    case (d[2:0])
      DIR_UP, DIR_UP_RIGHT, DIR_UP_LEFT:        return -1;
      DIR_DOWN_RIGHT, DIR_DOWN, DIR_DOWN_LEFT:  return 1;
      default:                                  return 0;
    endcase
  endfunction

  function automatic int col_step(input int d);
    case (d[2:0])
      DIR_UP_RIGHT, DIR_RIGHT, DIR_DOWN_RIGHT:  return 1;
      DIR_DOWN_LEFT, DIR_LEFT, DIR_UP_LEFT:     return -1;
      default:                                  return 0;
    endcase
  endfunction

  // Clamp the length: zero acts as one, anything past the store acts as full.
  function automatic int used_len();
    if (pattern_len_model == 0) return 1;
    if (pattern_len_model > PATTERN_MAX) return PATTERN_MAX;
    return int'(pattern_len_model);
  endfunction

  // Walk a search the way the block will and find the first grid read of a cell that
  // was never written.
  function automatic bit first_unwritten(input int r0, input int c0,
                                         output int ur, output int uc);
    int len;
    int d;
    int k;
    int r;
    int c;
    len = used_len();
    ur  = r0;
    uc  = c0;
    if (r0 >= GRID_ROWS || c0 >= GRID_COLS) return 1'b0;
    if (!grid_written[r0][c0]) return 1'b1;
    if (grid_model[r0][c0] != pattern_model[0]) return 1'b0;
    for (d = 0; d < 8; d++) begin
      r = r0;
      c = c0;
      for (k = 1; k < len; k++) begin
        r += row_step(d);
        c += col_step(d);
        if (r < 0 || r >= GRID_ROWS || c < 0 || c >= GRID_COLS) break;
        if (!grid_written[r][c]) begin
          ur = r;
          uc = c;
          return 1'b1;
        end
        if (grid_model[r][c] != pattern_model[k]) break;
      end
    end
    return 1'b0;
  endfunction

  // Mostly a two-letter alphabet so that words line up often, sometimes any byte.
  function automatic logic [7:0] pick_char();
    if ($urandom_range(7) == 0) return 8'($urandom);
    return $urandom_range(1) ? 8'h41 : 8'h42;
  endfunction

  function automatic gws_in_t make_req(input logic [1:0] op, input int r, input int c,
                                       input int p, input int ch);
    gws_in_t req;
    req.operation        = op;
    req.row              = r[4:0];
    req.column           = c[4:0];
    req.pattern_position = p[3:0];
    req.character        = ch[7:0];
    return req;
  endfunction

  // Update the shadow state and queue the match reports a request must cause.
  task automatic apply_request(input gws_in_t req);
    int       len;
    int       d;
    int       k;
    int       r;
    int       c;
    int       hits;
    bit       ok;
    gws_out_t held;
    held = '0;
    hits = 0;
    case (req.operation)
      OP_GRID_WR: begin
        if (req.column < GRID_COLS) begin
          grid_model[req.row][req.column]   = req.character;
          grid_written[req.row][req.column] = 1'b1;
        end
      end
      OP_PAT_WR: begin
        pattern_model[req.pattern_position] = req.character;
      end
      OP_SEARCH: begin
        len               = used_len();
        held.start_row    = req.row;
        held.start_column = req.column;
        if (req.column < GRID_COLS &&
            grid_model[req.row][req.column] == pattern_model[0]) begin
          for (d = 0; d < 8; d++) begin
            r  = req.row;
            c  = req.column;
            ok = 1'b1;
            for (k = 1; k < len && ok; k++) begin
              r += row_step(d);
              c += col_step(d);
              if (r < 0 || r >= GRID_ROWS || c < 0 || c >= GRID_COLS) ok = 1'b0;
              else if (grid_model[r][c] != pattern_model[k]) ok = 1'b0;
            end
            if (ok) begin
              // Hold back the latest hit so the final one can carry the last flag.
              if (hits > 0) match_reports.push_back(held);
              held.found     = 1'b1;
              held.direction = d[2:0];
              hits++;
            end
          end
        end
        if (hits == 0) begin
          held.found     = 1'b0;
          held.direction = DIR_UP;
        end
        held.last = 1'b1;
        match_reports.push_back(held);
      end
      default: ;
    endcase
  endtask

  // Offer one request, keep it steady until taken, then predict its outcome.
  // Valid stays high on return; the next call or a drain decides what follows.
  task automatic send_request(input gws_in_t req);
    int gap;
    gap = 0;
    if (in_idle_on) while ($urandom_range(99) < IDLE_PERCENT) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    do @(posedge clk); while (in_stall);
    apply_request(req);
  endtask

  task automatic write_cell(input int r, input int c, input int ch);
    send_request(make_req(OP_GRID_WR, r, c, $urandom, ch));
  endtask

  task automatic write_pattern(input int p, input int ch);
    send_request(make_req(OP_PAT_WR, $urandom, $urandom, p, ch));
  endtask

  // Write any cell the search would read before it was ever written, then search.
  task automatic search_from(input int r, input int c);
    int ur;
    int uc;
    while (first_unwritten(r, c, ur, uc)) write_cell(ur, uc, pick_char());
    send_request(make_req(OP_SEARCH, r, c, $urandom, $urandom));
  endtask

  // Drop valid, wait for every owed report, then let any trailing write finish.
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (match_reports.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_pattern_length(input int v);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_data  <= v[CFG_W-1:0];
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    pattern_len_model = v[CFG_W-1:0];
  endtask

  // Lay a fresh pattern of len characters along a random line and search from its start.
  // When allowed, the start is now and then anywhere, so the word may run off the grid edge.
  task automatic plant_word(input int len, input bit may_run_off);
    int         d;
    int         dr;
    int         dc;
    int         r0;
    int         c0;
    int         k;
    int         r;
    int         c;
    logic [7:0] word [0:PATTERN_MAX-1];
    d  = $urandom_range(7);
    dr = row_step(d);
    dc = col_step(d);
    if (may_run_off && $urandom_range(4) == 0) begin
      r0 = $urandom_range(GRID_ROWS - 1);
      c0 = $urandom_range(GRID_COLS - 1);
    end else begin
      if (dr < 0) r0 = $urandom_range(GRID_ROWS - 1, len - 1);
      else if (dr > 0) r0 = $urandom_range(GRID_ROWS - len, 0);
      else r0 = $urandom_range(GRID_ROWS - 1);
      if (dc < 0) c0 = $urandom_range(GRID_COLS - 1, len - 1);
      else if (dc > 0) c0 = $urandom_range(GRID_COLS - len, 0);
      else c0 = $urandom_range(GRID_COLS - 1);
    end
    for (k = 0; k < len; k++) begin
      word[k] = pick_char();
      write_pattern(k, word[k]);
    end
    for (k = 0; k < len; k++) begin
      r = r0 + k * dr;
      c = c0 + k * dc;
      if (r >= 0 && r < GRID_ROWS && c >= 0 && c < GRID_COLS) write_cell(r, c, word[k]);
    end
    plant_row = r0;
    plant_col = c0;
    search_from(r0, c0);
  endtask

  // Write every pattern slot so no search ever reads an unwritten one; grid cells are
  // written on demand ahead of each search.
  task automatic test_load_pattern();
    int p;
    for (p = 0; p < PATTERN_MAX; p++) write_pattern(p, pick_char());
  endtask

  // Field extremes, ignored writes, the unused operation, all eight directions at length one,
  // a start cell that does not match, and starts outside the grid.
  task automatic test_directed_cases();
    write_cell(0, 0, 8'h00);
    write_cell(GRID_ROWS - 1, GRID_COLS - 1, 8'hFF);
    write_cell(5, GRID_COLS, 8'h5A);
    write_cell(GRID_ROWS - 1, 31, 8'hFF);
    write_pattern(PATTERN_MAX - 1, 8'hFF);
    write_pattern(0, 8'h00);
    send_request(make_req(OP_UNUSED, 31, 31, 15, 8'hFF));
    send_request(make_req(OP_UNUSED, 0, 0, 0, 8'h00));
    search_from(0, 0);
    search_from(GRID_ROWS - 1, GRID_COLS - 1);
    write_pattern(0, 8'hFF);
    search_from(GRID_ROWS - 1, GRID_COLS - 1);
    search_from(0, GRID_COLS);
    search_from(GRID_ROWS - 1, 31);
    search_from(5, GRID_COLS - 1);
  endtask

  // Length register at zero, at the store size and past it.
  task automatic test_length_limits();
    set_pattern_length(0);
    search_from(0, 0);
    search_from(GRID_ROWS - 1, GRID_COLS - 1);
    set_pattern_length(PATTERN_MAX);
    plant_word(PATTERN_MAX, 1'b0);
    set_pattern_length(31);
    search_from(plant_row, plant_col);
    set_pattern_length(PATTERN_MAX + 1);
    search_from(plant_row, plant_col);
  endtask

  // Planted words at short lengths, some running off the grid edge.
  task automatic test_planted_words();
    int lens [0:1];
    int i;
    lens = '{2, 3};
    for (i = 0; i < 2; i++) begin
      set_pattern_length(lens[i]);
      plant_word(lens[i], 1'b1);
    end
  endtask

  // Mixed random traffic around the top-left corner, so cells are reused and lines run into
  // the edges; the first half runs with no idling on either side.
  task automatic test_random_mix();
    int i;
    int sel;
    int r;
    int c;
    set_pattern_length($urandom_range(3, 1));
    in_idle_on  = 1'b0;
    out_idle_on <= 1'b0;
    for (i = 0; i < 14; i++) begin
      if (i == 7) begin
        in_idle_on  = 1'b1;
        out_idle_on <= 1'b1;
      end
      sel = $urandom_range(99);
      r   = $urandom_range(3);
      c   = ($urandom_range(7) == 0) ? $urandom_range(31, GRID_COLS) : $urandom_range(3);
      if (sel < 50) search_from(r, c);
      else if (sel < 75) write_cell(r, c, pick_char());
      else if (sel < 85) write_pattern($urandom_range(PATTERN_MAX - 1), pick_char());
      else send_request(make_req(OP_UNUSED, $urandom, $urandom, $urandom, $urandom));
    end
  endtask

  // Hold off the result side for a long stretch while searches keep coming, so the block
  // backs up and stalls its request side.
  task automatic test_output_backpressure();
    set_pattern_length(1);
    holdoff_requests <= holdoff_requests + 1;
    repeat (8) search_from($urandom_range(3), $urandom_range(3));
  endtask

  task automatic check_field(input string name, input int exp_val, input int act_val);
    if (exp_val != act_val) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp_val, act_val);
      mismatch_count++;
    end
  endtask

  // Sample at the falling edge: what is seen here is what the next rising edge accepts.
  always @(negedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (match_reports.size() == 0) begin
        $display("%0t: unexpected result, expected none, got %h", $time, out_data);
        mismatch_count++;
      end else begin
        want = match_reports.pop_front();
        check_field("found", want.found, out_data.found);
        check_field("direction", want.direction, out_data.direction);
        check_field("start_row", want.start_row, out_data.start_row);
        check_field("start_column", want.start_column, out_data.start_column);
        check_field("last", want.last, out_data.last);
      end
    end
  end

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_load_pattern();
    test_directed_cases();
    test_length_limits();
    test_planted_words();
    test_random_mix();
    test_output_backpressure();
    wait_drained();
    if (mismatch_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
